/* hdl/brf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the byte ring buffer.
// No dependencies.
package brf_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        LVL_MID  = 2'd0,
        LVL_HIGH = 2'd1,
        LVL_LOW  = 2'd2
    } level_t;

    typedef enum logic [1:0] {
        CFG_CAPACITY  = 2'd0,
        CFG_OVERWRITE = 2'd1,
        CFG_HIGH_MARK = 2'd2,
        CFG_LOW_MARK  = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] CAPACITY_RST  = 8'd128;
    localparam logic [7:0] HIGH_MARK_RST = 8'd96;
    localparam logic [7:0] LOW_MARK_RST  = 8'd32;

endpackage

/* hdl/brf_ifs.sv */
`timescale 1ns / 1ps
// Request, response and configuration channels of the byte ring buffer.
// Depends on brf_pkg.
interface brf_in_if
    import brf_pkg::*;
();
    logic       valid;
    logic       ready;
    op_t        operation;
    logic [7:0] push_byte;
    logic [6:0] peek_index;

    modport source (output valid, operation, push_byte, peek_index, input ready);
    modport sink   (input valid, operation, push_byte, peek_index, output ready);
endinterface

interface brf_out_if
    import brf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] read_byte;
    logic [7:0] fill_count;
    logic       is_full;
    logic       is_empty;
    level_t     level;

    modport source (output valid, ok, read_byte, fill_count, is_full, is_empty, level,
                    input ready);
    modport sink   (input valid, ok, read_byte, fill_count, is_full, is_empty, level,
                    output ready);
endinterface

interface brf_cfg_if
    import brf_pkg::*;
();
    logic       valid;
    logic       ready;
    cfg_idx_t   index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/byte_ring_fifo_overwrite.sv */
`timescale 1ns / 1ps
// Byte ring buffer: push, pop, peek and clear on a single-port-write, sync-read RAM.
// Response registered in the cycle after the request is taken; the RAM read register
// doubles as the read_byte stage. Throughput: one request per cycle unless rsp stalls.
// Reset: pointers and count cleared, config registers to their defaults; RAM contents untouched.
// Depends on brf_pkg and the channel interfaces in brf_ifs.sv.
module byte_ring_fifo_overwrite
    import brf_pkg::*;
#(
    parameter int DEPTH = 128
)(
    input  logic          clk,
    input  logic          rst_n,
    brf_in_if.sink        req,
    brf_out_if.source     rsp,
    brf_cfg_if.sink       cfg
);

    // Capacity is an 8-bit register, so no more than 255 slots are ever addressed.
    localparam int         MD      = (DEPTH > 255) ? 255 : DEPTH;
    localparam int         PW      = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [7:0] CAP_MAX = 8'(MD);

    function automatic logic [7:0] eff_cap(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == 8'd0)
            r = 8'd1;
        else if (c > CAP_MAX)
            r = CAP_MAX;
        return r;
    endfunction

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [7:0] c);
        logic [8:0] n;
        n = 9'(p) + 9'd1;
        return (n >= {1'b0, c}) ? '0 : n[PW-1:0];
    endfunction

    logic [7:0]    cap_reg;
    logic          ovr_reg;
    logic [7:0]    hmark_reg;
    logic [7:0]    lmark_reg;

    logic [PW-1:0] wpos_reg, wpos_next;
    logic [PW-1:0] rpos_reg, rpos_next;
    logic [7:0]    held_reg, held_next;

    logic          ovalid_reg;
    logic          ok_reg, ok_next;
    logic          rsel_reg, rsel_next;
    logic [7:0]    fill_reg;
    logic          full_reg, full_next;
    logic          empty_reg, empty_next;
    level_t        level_reg, level_next;

    logic [7:0]    mem [MD];
    logic [7:0]    rdata_reg;

    logic          fire;
    logic          cfg_fire;
    logic          wr_en;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [8:0]    peek_sum;
    logic [8:0]    peek_pos;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign req.ready = !ovalid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        held_next = held_reg;
        ok_next   = 1'b0;
        rsel_next = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = rpos_reg;
        peek_sum  = 9'(rpos_reg) + 9'(req.peek_index);
        peek_pos  = (peek_sum >= {1'b0, cap_reg}) ? peek_sum - {1'b0, cap_reg} : peek_sum;

        unique case (req.operation)
            OP_PUSH:
            begin
                if (held_reg >= cap_reg) begin
                    // full: overwrite mode drops the oldest byte
                    if (ovr_reg) begin
                        rpos_next = adv(rpos_reg, cap_reg);
                        ok_next   = 1'b1;
                    end
                end
                else begin
                    held_next = held_reg + 8'd1;
                    ok_next   = 1'b1;
                end
                if (ok_next) begin
                    wr_en     = 1'b1;
                    wpos_next = adv(wpos_reg, cap_reg);
                end
            end
            OP_POP:
            begin
                if (held_reg != 8'd0) begin
                    rpos_next = adv(rpos_reg, cap_reg);
                    held_next = held_reg - 8'd1;
                    ok_next   = 1'b1;
                    rsel_next = 1'b1;
                end
            end
            OP_PEEK:
            begin
                rd_addr = peek_pos[PW-1:0];
                if ({1'b0, req.peek_index} < held_reg) begin
                    ok_next   = 1'b1;
                    rsel_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                wpos_next = '0;
                rpos_next = '0;
                held_next = 8'd0;
                ok_next   = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        rd_en      = fire && rsel_next;
        full_next  = (held_next == cap_reg);
        empty_next = (held_next == 8'd0);
        if (held_next >= hmark_reg)
            level_next = LVL_HIGH;
        else if (held_next <= lmark_reg)
            level_next = LVL_LOW;
        else
            level_next = LVL_MID;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg    <= eff_cap(CAPACITY_RST);
            ovr_reg    <= 1'b0;
            hmark_reg  <= HIGH_MARK_RST;
            lmark_reg  <= LOW_MARK_RST;
            wpos_reg   <= '0;
            rpos_reg   <= '0;
            held_reg   <= 8'd0;
            ovalid_reg <= 1'b0;
        end
        else begin
            if (cfg_fire) begin
                unique case (cfg.index)
                    CFG_CAPACITY:
                    begin
                        cap_reg  <= eff_cap(cfg.data);
                        wpos_reg <= '0;
                        rpos_reg <= '0;
                        held_reg <= 8'd0;
                    end
                    CFG_OVERWRITE: ovr_reg   <= cfg.data[0];
                    CFG_HIGH_MARK: hmark_reg <= cfg.data;
                    CFG_LOW_MARK:  lmark_reg <= cfg.data;
                    default:       ovr_reg   <= ovr_reg;
                endcase
            end
            else if (fire) begin
                wpos_reg <= wpos_next;
                rpos_reg <= rpos_next;
                held_reg <= held_next;
            end
            if (fire)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // response payload, held while the response stalls
    always_ff @(posedge clk)
    begin
        if (fire) begin
            ok_reg    <= ok_next;
            rsel_reg  <= rsel_next;
            fill_reg  <= held_next;
            full_reg  <= full_next;
            empty_reg <= empty_next;
            level_reg <= level_next;
        end
    end

    // slot RAM; a write is always visible to a read in a later cycle
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
            mem[wpos_reg] <= req.push_byte;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign rsp.valid      = ovalid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.read_byte  = rsel_reg ? rdata_reg : 8'd0;
    assign rsp.fill_count = fill_reg;
    assign rsp.is_full    = full_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.level      = level_reg;

endmodule

/* hdl/brf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the byte ring buffer, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_overwrite.
module brf_checker
    import brf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input op_t        req_operation,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_ok,
    input logic [7:0] rsp_read_byte,
    input logic       rsp_is_full,
    input logic       rsp_is_empty
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("taken request gave no response");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == OP_CLEAR |=> rsp_ok && rsp_is_empty)
        else $error("clear did not leave the buffer empty");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_read_byte == 8'd0)
        else $error("failed request returned a byte");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_is_full && rsp_is_empty))
        else $error("full and empty at once");

endmodule

bind byte_ring_fifo_overwrite brf_checker u_brf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ok        (rsp.ok),
    .rsp_read_byte (rsp.read_byte),
    .rsp_is_full   (rsp.is_full),
    .rsp_is_empty  (rsp.is_empty)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for byte_ring_fifo_overwrite: directed table, a full-depth fill, then random phases with idling.
// Responses are checked against a ring buffer predictor. Depends on brf_pkg, brf_ifs.sv and byte_ring_fifo_overwrite.
module tb_top;
    import brf_pkg::*;

    localparam int RING_DEPTH  = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    // capacities used by the random phases, phase 0 in the low byte
    localparam logic [63:0] PHASE_CAPS = {8'd128, 8'd9, 8'd2, 8'd200,
                                          8'd128, 8'd0, 8'd3, 8'd1};

    typedef struct packed {
        logic       ok;
        logic [7:0] rd;
        logic [7:0] cnt;
        logic       full;
        logic       empty;
        level_t     lvl;
    } ring_rsp_t;

    typedef struct packed {
        bit         is_cfg;
        cfg_idx_t   cidx;
        logic [7:0] cdata;
        op_t        op;
        logic [7:0] pb;
        logic [6:0] pi;
        bit         typed;
        ring_rsp_t  typed_rsp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    brf_in_if  req_if ();
    brf_out_if rsp_if ();
    brf_cfg_if cfg_if ();

    byte_ring_fifo_overwrite #(.DEPTH(RING_DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // predictor state and register copy
    logic [7:0] ring_mem [RING_DEPTH];
    int         ring_wr;
    int         ring_rd;
    int         ring_cnt;
    logic [7:0] reg_cap;
    logic       reg_ow;
    logic [7:0] reg_hi;
    logic [7:0] reg_lo;

    ring_rsp_t  pending_rsp [$];
    stim_row_t  stim_table [$];
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    bit         hold_kick = 1'b0;
    bit         hold_seen = 1'b0;
    int         hold_left = 0;

    function automatic int ring_next(input int p, input int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic ring_rsp_t ring_step(input op_t op, input logic [7:0] pb,
                                            input logic [6:0] pi);
        ring_rsp_t r;
        int        cap;
        int        p;
        cap = (reg_cap == 8'd0) ? 1 : (int'(reg_cap) > RING_DEPTH) ? RING_DEPTH : int'(reg_cap);
        r = '0;
        r.lvl = LVL_MID;
        case (op)
            OP_PUSH:
            begin
                if (ring_cnt >= cap)
                begin
                    // overwrite drops the oldest byte, count unchanged
                    if (reg_ow)
                    begin
                        ring_rd = ring_next(ring_rd, cap);
                        r.ok = 1'b1;
                    end
                end
                else
                begin
                    ring_cnt++;
                    r.ok = 1'b1;
                end
                if (r.ok)
                begin
                    ring_mem[ring_wr] = pb;
                    ring_wr = ring_next(ring_wr, cap);
                end
            end
            OP_POP:
            begin
                if (ring_cnt != 0)
                begin
                    r.rd = ring_mem[ring_rd];
                    ring_rd = ring_next(ring_rd, cap);
                    ring_cnt--;
                    r.ok = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (int'(pi) < ring_cnt)
                begin
                    p = ring_rd + int'(pi);
                    if (p >= cap)
                        p -= cap;
                    r.rd = ring_mem[p];
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                ring_wr = 0;
                ring_rd = 0;
                ring_cnt = 0;
                r.ok = 1'b1;
            end
        endcase
        // marks are compared raw, so values above the depth are legal
        if (ring_cnt >= int'(reg_hi))
            r.lvl = LVL_HIGH;
        else if (ring_cnt <= int'(reg_lo))
            r.lvl = LVL_LOW;
        r.cnt   = ring_cnt[7:0];
        r.full  = (ring_cnt == cap);
        r.empty = (ring_cnt == 0);
        return r;
    endfunction

    function automatic ring_rsp_t rsp_of(input logic ok, input logic [7:0] rd,
                                         input logic [7:0] cnt, input logic full,
                                         input logic empty, input level_t lvl);
        ring_rsp_t r;
        r.ok    = ok;
        r.rd    = rd;
        r.cnt   = cnt;
        r.full  = full;
        r.empty = empty;
        r.lvl   = lvl;
        return r;
    endfunction

    function automatic logic [7:0] pick_mark(input int top);
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return 8'($urandom_range(top));
        endcase
    endfunction

    task automatic add_req(input op_t op, input logic [7:0] pb, input logic [6:0] pi,
                           input bit typed, input ring_rsp_t typed_rsp);
        stim_row_t row;
        row = '0;
        row.op        = op;
        row.pb        = pb;
        row.pi        = pi;
        row.typed     = typed;
        row.typed_rsp = typed_rsp;
        stim_table.push_back(row);
    endtask

    task automatic add_cfg(input cfg_idx_t idx, input logic [7:0] data);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cidx   = idx;
        row.cdata  = data;
        stim_table.push_back(row);
    endtask

    // one request; the sender may then go idle for a while
    task automatic push_req(input op_t op, input logic [7:0] pb, input logic [6:0] pi,
                            input bit typed, input ring_rsp_t typed_rsp);
        ring_rsp_t got;
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.push_byte  <= pb;
        req_if.peek_index <= pi;
        do @(posedge clk); while (!req_if.ready);
        got = ring_step(op, pb, pi);
        pending_rsp.push_back(typed ? typed_rsp : got);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic send_random(input bit filling);
        op_t        op;
        int         r;
        logic [6:0] idx;
        r = $urandom_range(99);
        if (filling)
            op = (r < 70) ? OP_PUSH : (r < 82) ? OP_POP : (r < 97) ? OP_PEEK : OP_CLEAR;
        else
            op = (r < 20) ? OP_PUSH : (r < 75) ? OP_POP : (r < 97) ? OP_PEEK : OP_CLEAR;
        if (ring_cnt > 0 && $urandom_range(3) != 0)
            idx = 7'($urandom_range(ring_cnt - 1));
        else
            idx = 7'($urandom_range(127));
        push_req(op, 8'($urandom_range(255)), idx, 1'b0, '0);
    endtask

    // stop offering and wait for every outstanding response
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_CAPACITY:
            begin
                reg_cap  = data;
                ring_wr  = 0;
                ring_rd  = 0;
                ring_cnt = 0;
            end
            CFG_OVERWRITE: reg_ow = data[0];
            CFG_HIGH_MARK: reg_hi = data;
            default:       reg_lo = data;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // response checker
    always @(posedge clk)
    begin
        ring_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatch_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_if.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
                    mismatch_cnt++;
                end
                if (rsp_if.read_byte !== want.rd)
                begin
                    $error("read_byte: expected %0d, got %0d", want.rd, rsp_if.read_byte);
                    mismatch_cnt++;
                end
                if (rsp_if.fill_count !== want.cnt)
                begin
                    $error("fill_count: expected %0d, got %0d", want.cnt, rsp_if.fill_count);
                    mismatch_cnt++;
                end
                if (rsp_if.is_full !== want.full)
                begin
                    $error("is_full: expected %0d, got %0d", want.full, rsp_if.is_full);
                    mismatch_cnt++;
                end
                if (rsp_if.is_empty !== want.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.empty, rsp_if.is_empty);
                    mismatch_cnt++;
                end
                if (rsp_if.level !== want.lvl)
                begin
                    $error("level: expected %0d, got %0d", want.lvl, rsp_if.level);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when kicked
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick != hold_seen)
            begin
                hold_seen = hold_kick;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] cap;
        int         ecap;
        stim_row_t  row;

        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.operation  <= OP_PUSH;
        req_if.push_byte  <= 8'd0;
        req_if.peek_index <= 7'd0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_CAPACITY;
        cfg_if.data       <= 8'd0;

        ring_wr  = 0;
        ring_rd  = 0;
        ring_cnt = 0;
        reg_cap  = CAPACITY_RST;
        reg_ow   = 1'b0;
        reg_hi   = HIGH_MARK_RST;
        reg_lo   = LOW_MARK_RST;

        // defaults after reset: capacity 128, marks 96 / 32
        add_req(OP_POP,   8'h00, 7'd0,   1'b1, rsp_of(0, 8'h00, 8'd0, 0, 1, LVL_LOW));
        add_req(OP_PEEK,  8'h00, 7'd127, 1'b1, rsp_of(0, 8'h00, 8'd0, 0, 1, LVL_LOW));
        add_req(OP_PUSH,  8'h00, 7'd0,   1'b1, rsp_of(1, 8'h00, 8'd1, 0, 0, LVL_LOW));
        add_req(OP_PUSH,  8'hFF, 7'd127, 1'b1, rsp_of(1, 8'h00, 8'd2, 0, 0, LVL_LOW));
        add_req(OP_PEEK,  8'h00, 7'd1,   1'b0, '0);
        add_req(OP_PEEK,  8'h00, 7'd2,   1'b1, rsp_of(0, 8'h00, 8'd2, 0, 0, LVL_LOW));
        add_req(OP_POP,   8'hFF, 7'd0,   1'b0, '0);
        add_req(OP_CLEAR, 8'hAA, 7'h7F,  1'b1, rsp_of(1, 8'h00, 8'd0, 0, 1, LVL_LOW));
        // capacity 0 behaves as 1; marks at their extremes
        add_cfg(CFG_CAPACITY,  8'd0);
        add_cfg(CFG_HIGH_MARK, 8'd255);
        add_cfg(CFG_LOW_MARK,  8'd0);
        add_req(OP_PUSH,  8'h3C, 7'd0,   1'b1, rsp_of(1, 8'h00, 8'd1, 1, 0, LVL_MID));
        add_req(OP_PUSH,  8'hC3, 7'd0,   1'b1, rsp_of(0, 8'h00, 8'd1, 1, 0, LVL_MID));
        add_cfg(CFG_OVERWRITE, 8'd1);
        add_req(OP_PUSH,  8'h7E, 7'd0,   1'b1, rsp_of(1, 8'h00, 8'd1, 1, 0, LVL_MID));
        add_req(OP_POP,   8'h00, 7'd0,   1'b0, '0);
        // capacity above the depth is clamped
        add_cfg(CFG_CAPACITY,  8'd255);
        add_cfg(CFG_HIGH_MARK, 8'd0);
        add_cfg(CFG_LOW_MARK,  8'd255);
        add_req(OP_PUSH,  8'h55, 7'd0,   1'b1, rsp_of(1, 8'h00, 8'd1, 0, 0, LVL_HIGH));
        // two slots, overwrite on: wrap of both pointers
        add_cfg(CFG_CAPACITY,  8'd2);
        add_cfg(CFG_HIGH_MARK, 8'd2);
        add_cfg(CFG_LOW_MARK,  8'd1);
        add_req(OP_PUSH,  8'h11, 7'd0,   1'b0, '0);
        add_req(OP_PUSH,  8'h22, 7'd0,   1'b0, '0);
        add_req(OP_PUSH,  8'h33, 7'd0,   1'b0, '0);
        add_req(OP_PEEK,  8'h00, 7'd0,   1'b0, '0);
        add_req(OP_PEEK,  8'h00, 7'd1,   1'b0, '0);
        add_req(OP_POP,   8'h00, 7'd0,   1'b0, '0);
        add_req(OP_POP,   8'h00, 7'd0,   1'b0, '0);
        add_req(OP_POP,   8'h00, 7'd0,   1'b1, rsp_of(0, 8'h00, 8'd0, 0, 1, LVL_LOW));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.cidx, row.cdata);
            end
            else
                push_req(row.op, row.pb, row.pi, row.typed, row.typed_rsp);
        end

        // fill the full depth (requests stall while the receiver holds off), then read it all back
        settle();
        write_reg(CFG_CAPACITY,  8'd128);
        write_reg(CFG_OVERWRITE, 8'd0);
        write_reg(CFG_HIGH_MARK, 8'd128);
        write_reg(CFG_LOW_MARK,  8'd0);
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        hold_kick <= ~hold_kick;
        for (int n = 0; n < 135; n++)
            push_req(OP_PUSH, 8'($urandom_range(255)), 7'($urandom_range(127)), 1'b0, '0);
        push_req(OP_PEEK, 8'($urandom_range(255)), 7'd127, 1'b0, '0);
        for (int n = 0; n < 19; n++)
            push_req(OP_PEEK, 8'($urandom_range(255)), 7'($urandom_range(127)), 1'b0, '0);
        for (int n = 0; n < 130; n++)
            push_req(OP_POP, 8'($urandom_range(255)), 7'($urandom_range(127)), 1'b0, '0);

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            cap  = PHASE_CAPS[ph*8 +: 8];
            ecap = (cap == 8'd0) ? 1 : (int'(cap) > RING_DEPTH) ? RING_DEPTH : int'(cap);
            src_idle_pct = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 38 : 0;
            sink_stall_pct <= (ph % 4 == 2) ? 70 : (ph % 4 == 3) ? 38 : 0;
            write_reg(CFG_CAPACITY,  cap);
            write_reg(CFG_OVERWRITE, 8'($urandom_range(1)));
            write_reg(CFG_HIGH_MARK, pick_mark(ecap));
            write_reg(CFG_LOW_MARK,  pick_mark(ecap));
            // alternate fill-biased and drain-biased stretches
            for (int n = 0; n < 100; n++)
                send_random(((n / 40) % 2) == 0);
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
hdl/brf_pkg.sv
hdl/brf_ifs.sv
hdl/byte_ring_fifo_overwrite.sv
hdl/brf_checker.sv
dv/tb_top.sv
